@@ rtl/suffix_automaton_matcher_core_macros.svh @@
// ----------------------------------------------------------------------------
// suffix_automaton_matcher_core_macros
// Assertion helpers for the suffix automaton matcher.
// ----------------------------------------------------------------------------
// The enclosing module must provide clk and rst_n.
`ifndef SUFFIX_AUTOMATON_MATCHER_CORE_MACROS_SVH
`define SUFFIX_AUTOMATON_MATCHER_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SAM_CHECK(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sam check failed");

// Antecedent at one edge implies consequent at the next edge.
`define SAM_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sam check failed");

`endif

@@ rtl/sam_pkg.sv @@
// ----------------------------------------------------------------------------
// sam_pkg
// Shared sizes, codes, sequencer states and memory request types of the
// suffix automaton matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 256;
    localparam int NSTATES  = 2 * MAX_TEXT;

    localparam int SYM_W  = 8;
    localparam int ID_W   = $clog2(NSTATES);
    localparam int LEN_W  = $clog2(MAX_TEXT + 1);
    localparam int TXT_W  = $clog2(MAX_TEXT + 1);
    localparam int USED_W = $clog2(NSTATES + 1);
    localparam int EP_W   = 4;
    localparam int TR_AW  = ID_W + SYM_W;

    localparam logic [USED_W-1:0] USED_LIMIT = USED_W'(NSTATES - 2);
    localparam logic [TXT_W-1:0]  TEXT_LIMIT = TXT_W'(MAX_TEXT);
    localparam logic [EP_W-1:0]   EP_FIRST   = EP_W'(1);
    localparam logic [EP_W-1:0]   EP_LAST    = '1;
    localparam logic [SYM_W:0]    ROW_END    = (SYM_W + 1)'(ALPHABET);

    localparam logic KIND_ANSWER  = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_P_EV,
        S_X_LEN,
        S_X_WALK,
        S_X_LINK,
        S_X_LENP,
        S_X_LENQ,
        S_X_LINKQ,
        S_X_COPY,
        S_X_RED,
        S_X_RLINK,
        S_X_FIN1,
        S_X_FIN2
    } seq_t;

    // Transition entry: valid only when its epoch matches the live one and
    // the target is nonzero (the root is never a target).
    typedef struct packed {
        logic [EP_W-1:0] ep;
        logic [ID_W-1:0] tgt;
    } tr_entry_t;

    typedef struct packed {
        logic             we;
        logic [TR_AW-1:0] waddr;
        tr_entry_t        wdata;
        logic [TR_AW-1:0] raddr;
    } tr_req_t;

    typedef struct packed {
        logic             we;
        logic [ID_W-1:0]  waddr;
        logic [LEN_W-1:0] wdata;
        logic [ID_W-1:0]  raddr;
    } len_req_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic [ID_W-1:0] wdata;
        logic [ID_W-1:0] raddr;
    } link_req_t;

endpackage

`default_nettype wire

@@ rtl/sam_ram.sv @@
// ----------------------------------------------------------------------------
// sam_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/sam_ctrl.sv @@
// ----------------------------------------------------------------------------
// sam_ctrl
// Sequencer of the matcher: walks suffix links, clones states, copies rows,
// scrubs the table and follows pattern transitions through the memories.
// ----------------------------------------------------------------------------
`default_nettype none

`include "suffix_automaton_matcher_core_macros.svh"

module sam_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   opcode,
    input  wire logic [sam_pkg::SYM_W-1:0]    symbol,
    input  wire logic                         pattern_last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              result_kind,
    output logic                              found,
    output sam_pkg::tr_req_t                  tr_req,
    input  wire sam_pkg::tr_entry_t           tr_rdata,
    output sam_pkg::len_req_t                 len_req,
    input  wire logic [sam_pkg::LEN_W-1:0]    len_rdata,
    output sam_pkg::link_req_t                link_req,
    input  wire logic [sam_pkg::ID_W-1:0]     link_rdata
);

    sam_pkg::seq_t state_reg, state_next;

    logic [sam_pkg::ID_W-1:0]   p_reg, p_next;
    logic [sam_pkg::ID_W-1:0]   cur_reg, cur_next;
    logic [sam_pkg::ID_W-1:0]   cl_reg, cl_next;
    logic [sam_pkg::ID_W-1:0]   q_reg, q_next;
    logic [sam_pkg::SYM_W-1:0]  sym_reg, sym_next;
    logic                       plast_reg, plast_next;
    logic [sam_pkg::LEN_W-1:0]  lenp_reg, lenp_next;
    logic [sam_pkg::TR_AW-1:0]  cnt_reg, cnt_next;
    logic [sam_pkg::USED_W-1:0] used_reg, used_next;
    logic [sam_pkg::ID_W-1:0]   last_reg, last_next;
    logic [sam_pkg::TXT_W-1:0]  txt_reg, txt_next;
    logic [sam_pkg::ID_W-1:0]   qs_reg, qs_next;
    logic                       qf_reg, qf_next;
    logic [sam_pkg::EP_W-1:0]   ep_reg, ep_next;
    logic                       ov_reg, ov_next;
    logic                       kind_reg, kind_next;
    logic                       found_reg, found_next;

    logic                       accept;
    logic                       full;
    logic                       t_valid;
    logic                       p_root;
    logic                       sweep_done;
    logic                       copy_done;
    logic                       len_match;
    logic [sam_pkg::LEN_W-1:0]  lenp_plus;
    logic [sam_pkg::TR_AW-1:0]  cnt_m1;

    assign in_ready    = (state_reg == sam_pkg::S_IDLE) && (!ov_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign full        = (txt_reg >= sam_pkg::TEXT_LIMIT) || (used_reg > sam_pkg::USED_LIMIT);
    assign t_valid     = (tr_rdata.ep == ep_reg) && (tr_rdata.tgt != '0);
    assign p_root      = (p_reg == '0);
    assign sweep_done  = (cnt_reg == '1);
    assign copy_done   = (cnt_reg[sam_pkg::SYM_W:0] == sam_pkg::ROW_END);
    assign lenp_plus   = lenp_reg + sam_pkg::LEN_W'(1);
    assign len_match   = (lenp_plus == len_rdata);
    assign cnt_m1      = cnt_reg - sam_pkg::TR_AW'(1);
    assign out_valid   = ov_reg;
    assign result_kind = kind_reg;
    assign found       = found_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sam_pkg::S_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = sam_pkg::S_IDLE;
                end
            end
            sam_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        sam_pkg::OP_APPEND:
                        begin
                            if (!full)
                            begin
                                state_next = sam_pkg::S_X_LEN;
                            end
                        end
                        sam_pkg::OP_QUERY:
                        begin
                            if (!qf_reg)
                            begin
                                state_next = sam_pkg::S_P_EV;
                            end
                        end
                        sam_pkg::OP_CLEAR:
                        begin
                            if (ep_reg == sam_pkg::EP_LAST)
                            begin
                                state_next = sam_pkg::S_SWEEP;
                            end
                        end
                        default: state_next = sam_pkg::S_IDLE;
                    endcase
                end
            end
            sam_pkg::S_P_EV:  state_next = sam_pkg::S_IDLE;
            sam_pkg::S_X_LEN: state_next = sam_pkg::S_X_WALK;
            sam_pkg::S_X_WALK:
            begin
                if (t_valid)
                begin
                    state_next = sam_pkg::S_X_LENP;
                end
                else if (p_root)
                begin
                    state_next = sam_pkg::S_IDLE;
                end
                else
                begin
                    state_next = sam_pkg::S_X_LINK;
                end
            end
            sam_pkg::S_X_LINK: state_next = sam_pkg::S_X_WALK;
            sam_pkg::S_X_LENP: state_next = sam_pkg::S_X_LENQ;
            sam_pkg::S_X_LENQ:
            begin
                state_next = len_match ? sam_pkg::S_IDLE : sam_pkg::S_X_LINKQ;
            end
            sam_pkg::S_X_LINKQ: state_next = sam_pkg::S_X_COPY;
            sam_pkg::S_X_COPY:
            begin
                if (copy_done)
                begin
                    state_next = sam_pkg::S_X_RED;
                end
            end
            sam_pkg::S_X_RED:
            begin
                if (t_valid && (tr_rdata.tgt == q_reg) && !p_root)
                begin
                    state_next = sam_pkg::S_X_RLINK;
                end
                else
                begin
                    state_next = sam_pkg::S_X_FIN1;
                end
            end
            sam_pkg::S_X_RLINK: state_next = sam_pkg::S_X_RED;
            sam_pkg::S_X_FIN1:  state_next = sam_pkg::S_X_FIN2;
            sam_pkg::S_X_FIN2:  state_next = sam_pkg::S_IDLE;
            default:            state_next = sam_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory requests and results
    always_comb
    begin
        p_next     = p_reg;
        cur_next   = cur_reg;
        cl_next    = cl_reg;
        q_next     = q_reg;
        sym_next   = sym_reg;
        plast_next = plast_reg;
        lenp_next  = lenp_reg;
        cnt_next   = cnt_reg;
        used_next  = used_reg;
        last_next  = last_reg;
        txt_next   = txt_reg;
        qs_next    = qs_reg;
        qf_next    = qf_reg;
        ep_next    = ep_reg;
        ov_next    = ov_reg && !out_ready;
        kind_next  = kind_reg;
        found_next = found_reg;

        tr_req     = '0;
        len_req    = '0;
        link_req   = '0;

        case (state_reg)
            sam_pkg::S_SWEEP:
            begin
                tr_req.we    = 1'b1;
                tr_req.waddr = cnt_reg;
                cnt_next     = cnt_reg + sam_pkg::TR_AW'(1);
                if (sweep_done)
                begin
                    ep_next = sam_pkg::EP_FIRST;
                end
            end
            sam_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    sym_next   = symbol;
                    plast_next = pattern_last;
                    case (opcode)
                        sam_pkg::OP_APPEND:
                        begin
                            if (full)
                            begin
                                ov_next    = 1'b1;
                                kind_next  = sam_pkg::KIND_REFUSED;
                                found_next = 1'b0;
                            end
                            else
                            begin
                                cur_next      = used_reg[sam_pkg::ID_W-1:0];
                                used_next     = used_reg + sam_pkg::USED_W'(1);
                                p_next        = last_reg;
                                len_req.raddr = last_reg;
                            end
                        end
                        sam_pkg::OP_QUERY:
                        begin
                            tr_req.raddr = {qs_reg, symbol};
                            if (qf_reg && pattern_last)
                            begin
                                ov_next    = 1'b1;
                                kind_next  = sam_pkg::KIND_ANSWER;
                                found_next = 1'b0;
                                qs_next    = '0;
                                qf_next    = 1'b0;
                            end
                        end
                        sam_pkg::OP_CLEAR:
                        begin
                            used_next = sam_pkg::USED_W'(1);
                            last_next = '0;
                            txt_next  = '0;
                            qs_next   = '0;
                            qf_next   = 1'b0;
                            cnt_next  = '0;
                            // bump the epoch; on wrap, scrub the table instead
                            ep_next   = (ep_reg == sam_pkg::EP_LAST) ? ep_reg
                                                                     : ep_reg + sam_pkg::EP_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            sam_pkg::S_P_EV:
            begin
                if (plast_reg)
                begin
                    ov_next    = 1'b1;
                    kind_next  = sam_pkg::KIND_ANSWER;
                    found_next = t_valid;
                    qs_next    = '0;
                    qf_next    = 1'b0;
                end
                else if (t_valid)
                begin
                    qs_next = tr_rdata.tgt;
                end
                else
                begin
                    qf_next = 1'b1;
                end
            end
            sam_pkg::S_X_LEN:
            begin
                len_req.we    = 1'b1;
                len_req.waddr = cur_reg;
                len_req.wdata = ((last_reg == '0) ? '0 : len_rdata) + sam_pkg::LEN_W'(1);
                tr_req.raddr  = {p_reg, sym_reg};
            end
            sam_pkg::S_X_WALK:
            begin
                if (t_valid)
                begin
                    q_next        = tr_rdata.tgt;
                    len_req.raddr = p_reg;
                end
                else
                begin
                    tr_req.we        = 1'b1;
                    tr_req.waddr     = {p_reg, sym_reg};
                    tr_req.wdata.ep  = ep_reg;
                    tr_req.wdata.tgt = cur_reg;
                    if (p_root)
                    begin
                        link_req.we    = 1'b1;
                        link_req.waddr = cur_reg;
                        link_req.wdata = '0;
                        last_next      = cur_reg;
                        txt_next       = txt_reg + sam_pkg::TXT_W'(1);
                    end
                    else
                    begin
                        link_req.raddr = p_reg;
                    end
                end
            end
            sam_pkg::S_X_LINK, sam_pkg::S_X_RLINK:
            begin
                p_next       = link_rdata;
                tr_req.raddr = {link_rdata, sym_reg};
            end
            sam_pkg::S_X_LENP:
            begin
                lenp_next     = p_root ? '0 : len_rdata;
                len_req.raddr = q_reg;
            end
            sam_pkg::S_X_LENQ:
            begin
                if (len_match)
                begin
                    link_req.we    = 1'b1;
                    link_req.waddr = cur_reg;
                    link_req.wdata = q_reg;
                    last_next      = cur_reg;
                    txt_next       = txt_reg + sam_pkg::TXT_W'(1);
                end
                else
                begin
                    cl_next        = used_reg[sam_pkg::ID_W-1:0];
                    used_next      = used_reg + sam_pkg::USED_W'(1);
                    len_req.we     = 1'b1;
                    len_req.waddr  = used_reg[sam_pkg::ID_W-1:0];
                    len_req.wdata  = lenp_plus;
                    link_req.raddr = q_reg;
                end
            end
            sam_pkg::S_X_LINKQ:
            begin
                link_req.we    = 1'b1;
                link_req.waddr = cl_reg;
                link_req.wdata = link_rdata;
                cnt_next       = '0;
            end
            sam_pkg::S_X_COPY:
            begin
                // read column cnt of q, write column cnt-1 of the clone
                cnt_next = cnt_reg + sam_pkg::TR_AW'(1);
                if (copy_done)
                begin
                    tr_req.raddr = {p_reg, sym_reg};
                end
                else
                begin
                    tr_req.raddr = {q_reg, cnt_reg[sam_pkg::SYM_W-1:0]};
                end
                if (cnt_reg != '0)
                begin
                    tr_req.we        = 1'b1;
                    tr_req.waddr     = {cl_reg, cnt_m1[sam_pkg::SYM_W-1:0]};
                    tr_req.wdata.ep  = ep_reg;
                    tr_req.wdata.tgt = t_valid ? tr_rdata.tgt : '0;
                end
            end
            sam_pkg::S_X_RED:
            begin
                if (t_valid && (tr_rdata.tgt == q_reg))
                begin
                    tr_req.we        = 1'b1;
                    tr_req.waddr     = {p_reg, sym_reg};
                    tr_req.wdata.ep  = ep_reg;
                    tr_req.wdata.tgt = cl_reg;
                    link_req.raddr   = p_reg;
                end
            end
            sam_pkg::S_X_FIN1:
            begin
                link_req.we    = 1'b1;
                link_req.waddr = cur_reg;
                link_req.wdata = cl_reg;
            end
            sam_pkg::S_X_FIN2:
            begin
                link_req.we    = 1'b1;
                link_req.waddr = q_reg;
                link_req.wdata = cl_reg;
                last_next      = cur_reg;
                txt_next       = txt_reg + sam_pkg::TXT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sam_pkg::S_SWEEP;
            cnt_reg   <= '0;
            used_reg  <= sam_pkg::USED_W'(1);
            last_reg  <= '0;
            txt_reg   <= '0;
            qs_reg    <= '0;
            qf_reg    <= 1'b0;
            ep_reg    <= sam_pkg::EP_FIRST;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            used_reg  <= used_next;
            last_reg  <= last_next;
            txt_reg   <= txt_next;
            qs_reg    <= qs_next;
            qf_reg    <= qf_next;
            ep_reg    <= ep_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        cur_reg   <= cur_next;
        cl_reg    <= cl_next;
        q_reg     <= q_next;
        sym_reg   <= sym_next;
        plast_reg <= plast_next;
        lenp_reg  <= lenp_next;
        kind_reg  <= kind_next;
        found_reg <= found_next;
    end

    `SAM_CHECK(a_used_cap, used_reg <= sam_pkg::USED_W'(sam_pkg::NSTATES))
    `SAM_CHECK(a_text_cap, txt_reg <= sam_pkg::TEXT_LIMIT)
    `SAM_CHECK(a_last_live, {1'b0, last_reg} < used_reg)
    `SAM_CHECK(a_epoch_live, (state_reg == sam_pkg::S_SWEEP) || (ep_reg != '0))
    `SAM_CHECK_NEXT(a_append_busy, accept && (opcode == sam_pkg::OP_APPEND) && !full, !in_ready)

endmodule

`default_nettype wire

@@ rtl/suffix_automaton_matcher_core.sv @@
// ----------------------------------------------------------------------------
// suffix_automaton_matcher_core
// Online suffix automaton over a byte text with substring pattern queries.
// ----------------------------------------------------------------------------
// One item at a time; in_ready is low while an item is in work. A pattern
// symbol costs one transition-table read, evaluated in S_P_EV; a refused
// text symbol, or a pattern symbol after the pattern failed, ends in S_IDLE.
// A text symbol passes S_X_LEN and S_X_WALK, plus S_X_LINK per suffix-link
// step; a walk ending on an existing transition adds S_X_LENP and S_X_LENQ
// for the length compare, and a clone adds S_X_LINKQ, the row copy in
// S_X_COPY, S_X_RED and the link writes in S_X_FIN1 and S_X_FIN2, plus
// S_X_RLINK per redirected transition that moves the walk on. Each memory has
// one read and one write port. A clear bumps a table epoch; after reset, and
// on every 15th clear, the table is scrubbed with in_ready low.
`default_nettype none

module suffix_automaton_matcher_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                opcode,
    input  wire logic [sam_pkg::SYM_W-1:0] symbol,
    input  wire logic                      pattern_last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           result_kind,
    output logic                           found
);

    sam_pkg::tr_req_t             tr_req;
    sam_pkg::tr_entry_t           tr_rdata;
    sam_pkg::len_req_t            len_req;
    logic [sam_pkg::LEN_W-1:0]    len_rdata;
    sam_pkg::link_req_t           link_req;
    logic [sam_pkg::ID_W-1:0]     link_rdata;

    sam_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .symbol       (symbol),
        .pattern_last (pattern_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .found        (found),
        .tr_req       (tr_req),
        .tr_rdata     (tr_rdata),
        .len_req      (len_req),
        .len_rdata    (len_rdata),
        .link_req     (link_req),
        .link_rdata   (link_rdata)
    );

    sam_ram #(
        .DATA_W ($bits(sam_pkg::tr_entry_t)),
        .ADDR_W (sam_pkg::TR_AW)
    ) u_tr_ram (
        .clk   (clk),
        .we    (tr_req.we),
        .waddr (tr_req.waddr),
        .wdata (tr_req.wdata),
        .raddr (tr_req.raddr),
        .rdata (tr_rdata)
    );

    sam_ram #(
        .DATA_W (sam_pkg::LEN_W),
        .ADDR_W (sam_pkg::ID_W)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_req.we),
        .waddr (len_req.waddr),
        .wdata (len_req.wdata),
        .raddr (len_req.raddr),
        .rdata (len_rdata)
    );

    sam_ram #(
        .DATA_W (sam_pkg::ID_W),
        .ADDR_W (sam_pkg::ID_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

endmodule

`default_nettype wire
